// ===== rtl/bfra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_pkg
// Shared types and constants for the bitmap free-run allocator.
// ----------------------------------------------------------------------------
package bfra_pkg;

  localparam int MAX_BYTES  = 128;
  localparam int IDX_SPACE  = 128;
  localparam int LIMIT      = (MAX_BYTES < IDX_SPACE) ? MAX_BYTES : IDX_SPACE;
  localparam int BYTE_AW    = $clog2(MAX_BYTES);
  localparam int MAP_W      = 8;
  localparam int USED_W     = $clog2(LIMIT + 1);
  localparam int NBITS_W    = USED_W + 3;
  localparam int IDX_W      = 10;
  localparam int LEN_W      = 11;
  localparam int OP_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SCAN  = 2'd0,
    OP_TEST  = 2'd1,
    OP_SET   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] run_out;
  } scan_res_t;

endpackage

// ===== rtl/bfra_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_mem
// Occupancy byte store with one write and one registered read port.
// Per-entry valid bits make unwritten bytes read as zero after reset.
// ----------------------------------------------------------------------------
module bfra_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        we,
  input  logic [bfra_pkg::BYTE_AW-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic [bfra_pkg::BYTE_AW-1:0] raddr,
  output logic [7:0]                  rdata
);

  logic [7:0]                     mem [bfra_pkg::MAX_BYTES];
  logic [bfra_pkg::MAX_BYTES-1:0] vld_r;
  logic [7:0]                     q_r;
  logic                           qv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      qv_r <= vld_r[raddr];
    end
  end

  assign rdata = qv_r ? q_r : 8'h00;

endmodule

// ===== rtl/bfra_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_scan
// Byte scan unit: extends the current free-run count over one map byte and
// reports whether a run of the requested length completes and where it starts.
// ----------------------------------------------------------------------------
module bfra_scan (
  input  logic [7:0]                   map_byte,
  input  logic [bfra_pkg::BYTE_AW-1:0] byte_addr,
  input  logic [bfra_pkg::LEN_W-1:0]   run_in,
  input  logic [bfra_pkg::LEN_W-1:0]   run_length,
  output bfra_pkg::scan_res_t          res
);

  logic [bfra_pkg::LEN_W-1:0] run;
  logic                       hit;
  logic [2:0]                 hit_pos;
  logic [bfra_pkg::LEN_W-1:0] last_idx;
  logic [bfra_pkg::LEN_W-1:0] start_full;

  always_comb begin
    run     = run_in;
    hit     = 1'b0;
    hit_pos = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (!hit) begin
        if (map_byte[i]) begin
          run = '0;
        end else begin
          run = run + 1'b1;
          if (run == run_length) begin
            hit     = 1'b1;
            hit_pos = 3'(i);
          end
        end
      end
    end
    last_idx   = bfra_pkg::LEN_W'({byte_addr, hit_pos});
    start_full = last_idx + 1'b1 - run_length;
    res.hit     = hit;
    res.start   = start_full[bfra_pkg::IDX_W-1:0];
    res.run_out = run;
  end

endmodule

// ===== rtl/bitmap_free_run_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_free_run_allocator
// First-fit contiguous bitmap allocator with scan, test, set and clear.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// its single result has been shown on the out_ ports for one cycle with
// out_valid, and the receiver must take it then. A test, set or clear passes
// through the read, modify and done states before the result strobe, because
// the map byte is read through the registered port of the byte store and then
// modified. A scan primes the read of byte zero, then walks the map one byte
// per cycle through the scan unit, visiting at most the number of bytes in
// use (map_bytes clamped to 128), and then shows its result. An out of range
// index, a zero run length or a run longer than the map goes straight to the
// result strobe. The map reads as all zero right after reset, with no wait.
module bitmap_free_run_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bfra_pkg::OP_W-1:0]     in_operation,
  input  logic [bfra_pkg::IDX_W-1:0]    in_bit_index,
  input  logic [bfra_pkg::LEN_W-1:0]    in_run_length,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [bfra_pkg::IDX_W-1:0]    out_run_start,
  output logic                          out_bit_value,
  output logic                          out_out_of_range,
  input  logic                          cfg_we,
  input  logic [bfra_pkg::MAP_W-1:0]    cfg_wdata
);

  bfra_pkg::state_t state_r, state_nxt;
  bfra_pkg::op_t    op_r, op_nxt, in_op;

  logic [bfra_pkg::MAP_W-1:0]   map_bytes_r;
  logic [bfra_pkg::USED_W-1:0]  used_now;
  logic [bfra_pkg::NBITS_W-1:0] nbits_now;
  logic [bfra_pkg::USED_W-1:0]  used_r, used_nxt;
  logic [bfra_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [bfra_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [bfra_pkg::BYTE_AW-1:0] pb_r, pb_nxt;
  logic [bfra_pkg::LEN_W-1:0]   run_r, run_nxt;
  logic                         found_r, found_nxt;
  logic [bfra_pkg::IDX_W-1:0]   rstart_r, rstart_nxt;
  logic                         val_r, val_nxt;
  logic                         oor_r, oor_nxt;

  logic                         in_oor;
  logic                         in_scan_ok;
  logic                         last_byte;

  logic                         mem_we;
  logic [bfra_pkg::BYTE_AW-1:0] mem_raddr;
  logic [bfra_pkg::BYTE_AW-1:0] mem_waddr;
  logic [7:0]                   mem_wdata;
  logic [7:0]                   mem_rdata;

  bfra_pkg::scan_res_t          scan_res;

  bfra_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bfra_scan u_scan (
    .map_byte   (mem_rdata),
    .byte_addr  (pb_r),
    .run_in     (run_r),
    .run_length (len_r),
    .res        (scan_res)
  );

  assign in_op     = bfra_pkg::op_t'(in_operation);
  assign used_now  = (map_bytes_r > bfra_pkg::MAP_W'(bfra_pkg::LIMIT))
                   ? bfra_pkg::USED_W'(bfra_pkg::LIMIT)
                   : bfra_pkg::USED_W'(map_bytes_r);
  assign nbits_now = {used_now, 3'b000};

  assign in_oor     = bfra_pkg::NBITS_W'(in_bit_index) >= nbits_now;
  assign in_scan_ok = (in_run_length != '0)
                   && (bfra_pkg::NBITS_W'(in_run_length) <= nbits_now);
  assign last_byte  = bfra_pkg::USED_W'(pb_r) == (used_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfra_pkg::ST_IDLE;
      map_bytes_r <= bfra_pkg::MAP_W'(bfra_pkg::MAX_BYTES);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        map_bytes_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    used_r   <= used_nxt;
    idx_r    <= idx_nxt;
    len_r    <= len_nxt;
    pb_r     <= pb_nxt;
    run_r    <= run_nxt;
    found_r  <= found_nxt;
    rstart_r <= rstart_nxt;
    val_r    <= val_nxt;
    oor_r    <= oor_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfra_pkg::ST_IDLE: begin
        if (start) begin
          if (in_op == bfra_pkg::OP_SCAN) begin
            state_nxt = in_scan_ok ? bfra_pkg::ST_PRIME : bfra_pkg::ST_DONE;
          end else begin
            state_nxt = in_oor ? bfra_pkg::ST_DONE : bfra_pkg::ST_READ;
          end
        end
      end
      bfra_pkg::ST_PRIME:  state_nxt = bfra_pkg::ST_SCAN;
      bfra_pkg::ST_SCAN: begin
        if (scan_res.hit || last_byte) begin
          state_nxt = bfra_pkg::ST_DONE;
        end
      end
      bfra_pkg::ST_READ:   state_nxt = bfra_pkg::ST_MODIFY;
      bfra_pkg::ST_MODIFY: state_nxt = bfra_pkg::ST_DONE;
      bfra_pkg::ST_DONE:   state_nxt = bfra_pkg::ST_IDLE;
      default:             state_nxt = bfra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_nxt     = op_r;
    used_nxt   = used_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    pb_nxt     = pb_r;
    run_nxt    = run_r;
    found_nxt  = found_r;
    rstart_nxt = rstart_r;
    val_nxt    = val_r;
    oor_nxt    = oor_r;
    unique case (state_r)
      bfra_pkg::ST_IDLE: begin
        op_nxt     = in_op;
        used_nxt   = used_now;
        idx_nxt    = in_bit_index;
        len_nxt    = in_run_length;
        found_nxt  = 1'b0;
        rstart_nxt = '0;
        val_nxt    = 1'b0;
        oor_nxt    = (in_op != bfra_pkg::OP_SCAN) && in_oor;
      end
      bfra_pkg::ST_PRIME: begin
        pb_nxt  = '0;
        run_nxt = '0;
      end
      bfra_pkg::ST_SCAN: begin
        if (scan_res.hit) begin
          found_nxt  = 1'b1;
          rstart_nxt = scan_res.start;
        end else begin
          run_nxt = scan_res.run_out;
          pb_nxt  = pb_r + 1'b1;
        end
      end
      bfra_pkg::ST_MODIFY: begin
        if (op_r == bfra_pkg::OP_TEST) begin
          val_nxt = mem_rdata[idx_r[2:0]];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    busy      = state_r != bfra_pkg::ST_IDLE;
    out_valid = state_r == bfra_pkg::ST_DONE;
    mem_waddr = idx_r[bfra_pkg::IDX_W-1:3];
    mem_we    = 1'b0;
    mem_wdata = mem_rdata;
    mem_raddr = idx_r[bfra_pkg::IDX_W-1:3];
    unique case (state_r)
      bfra_pkg::ST_PRIME: mem_raddr = '0;
      bfra_pkg::ST_SCAN:  mem_raddr = pb_r + 1'b1;
      bfra_pkg::ST_MODIFY: begin
        case (op_r)
          bfra_pkg::OP_SET: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | (8'h01 << idx_r[2:0]);
          end
          bfra_pkg::OP_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~(8'h01 << idx_r[2:0]);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign out_found        = found_r;
  assign out_run_start    = rstart_r;
  assign out_bit_value    = val_r;
  assign out_out_of_range = oor_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_found_vs_test: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && (out_bit_value || out_out_of_range)))
    else $error("scan result mixed with a bit operation result");

  a_no_write_oor: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !oor_r && (state_r == bfra_pkg::ST_MODIFY))
    else $error("map written outside a valid bit operation");

endmodule
